// ----- hw/rtl/tsr_pkg.sv -----
// Shared types and constants of the triangle span rasterizer.
// No dependencies.
`default_nettype none

package tsr_pkg;

    localparam int COORD_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ENTRY_W = 2 * COORD_W;

    localparam logic [COORD_W-1:0] COL_MAX = '1;
    localparam logic [COORD_W-1:0] COL_MIN = '0;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CHAR_W-1:0]  char_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by_row;
        coord_t cx;
        coord_t cy;
        char_t  fill_char;
    } tri_t;

    typedef struct packed {
        coord_t row;
        coord_t span_start;
        coord_t span_end;
        char_t  span_char;
        logic   last_span;
    } span_t;

    typedef enum logic [1:0] {
        EDGE_01 = 2'd0,
        EDGE_12 = 2'd1,
        EDGE_02 = 2'd2
    } edge_sel_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsr_tri_if.sv -----
// Valid/ready channel that carries one triangle request.
// Depends on tsr_pkg.
`default_nettype none

interface tsr_tri_if
    import tsr_pkg::*;
();
    logic valid;
    logic ready;
    tri_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tsr_span_if.sv -----
// Valid/ready channel that carries one span request.
// Depends on tsr_pkg.
`default_nettype none

interface tsr_span_if
    import tsr_pkg::*;
();
    logic  valid;
    logic  ready;
    span_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tsr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ----- hw/rtl/triangle_span_rasterizer_top.sv -----
// Triangle span rasterizer top level: vertex sort, init pass, Bresenham edge walk
// and span emission around one row RAM. Depends on tsr_pkg, tsr_tri_if, tsr_span_if,
// tsr_ram.
//
// One triangle request is taken at a time. The rows it covers (count = height + 1,
// capped at ROWS) are kept as {left, right} pairs in a single RAM with one write and
// one read port. A triangle first presets the rows, then per edge runs a setup step
// and walks one edge pixel per cycle (read-modify-write pipelined through the RAM
// with forwarding), then drains, and emits each span with a RAM read and an output
// load, waiting out any stall on the span channel. A new triangle is accepted as
// soon as the last span sits in the output register.
`default_nettype none

module triangle_span_rasterizer_top
    import tsr_pkg::*;
#(
    parameter int ROWS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tsr_tri_if.sink   triangle,
    tsr_span_if.source span
);
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t    state_reg;
    vertex_t   v0_reg, v1_reg, v2_reg;
    coord_t    top_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] row_idx_reg;
    char_t     char_reg;
    edge_sel_t edge_reg;
    coord_t    step_x_reg, step_y_reg;
    logic signed [7:0] step_error_reg;

    logic          p1_valid_reg;
    coord_t        p1_x_reg;
    logic [AW-1:0] p1_addr_reg;

    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic  out_valid_reg;
    span_t out_reg;

    // vertex sort
    vertex_t s0, s1, s2, t0, t1, t2;
    coord_t  top_c, bot_c;
    logic [6:0] height1;
    logic [CW-1:0] count_c;

    always_comb
    begin
        s0 = '{x: triangle.data.ax, y: triangle.data.ay};
        s1 = '{x: triangle.data.bx, y: triangle.data.by_row};
        s2 = '{x: triangle.data.cx, y: triangle.data.cy};
        t0 = s0;
        t1 = s1;
        t2 = s2;
        if (s2.x < s0.x || s1.x < s0.x)
        begin
            if (s2.x < s1.x)
            begin
                t0 = s2;
                t2 = s0;
            end
            else
            begin
                t0 = s1;
                t1 = s0;
            end
        end
        s0 = t0;
        s1 = t1;
        s2 = t2;
        if (t2.x < t1.x)
        begin
            s1 = t2;
            s2 = t1;
        end
        top_c = (s0.y < s1.y) ? s0.y : s1.y;
        top_c = (top_c < s2.y) ? top_c : s2.y;
        bot_c = (s0.y > s1.y) ? s0.y : s1.y;
        bot_c = (bot_c > s2.y) ? bot_c : s2.y;
        height1 = {1'b0, bot_c} - {1'b0, top_c} + 7'd1;
        count_c = (height1 > 7'(ROWS)) ? CW'(ROWS) : CW'(height1);
    end

    // edge endpoints and stepper
    vertex_t e_start, e_end;
    logic signed [8:0] dx, dy, err9, e2, err_sum, init_err;
    logic   c_x, c_y, at_end, in_range;
    coord_t off;
    coord_t step_x_next, step_y_next;
    logic signed [7:0] step_error_next;

    always_comb
    begin
        unique case (edge_reg)
            EDGE_01:
            begin
                e_start = v0_reg;
                e_end   = v1_reg;
            end
            EDGE_12:
            begin
                e_start = v1_reg;
                e_end   = v2_reg;
            end
            default:
            begin
                e_start = v0_reg;
                e_end   = v2_reg;
            end
        endcase
        dx = (e_end.x > e_start.x) ? 9'(e_end.x - e_start.x) : 9'(e_start.x - e_end.x);
        dy = (e_end.y > e_start.y) ? -9'(e_end.y - e_start.y) : -9'(e_start.y - e_end.y);
        init_err = dx + dy;
        err9 = 9'(step_error_reg);
        e2 = err9 <<< 1;
        c_x = (e2 >= dy);
        c_y = (e2 <= dx);
        err_sum = err9 + (c_x ? dy : 9'sd0) + (c_y ? dx : 9'sd0);
        step_error_next = err_sum[7:0];
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        if (c_x)
        begin
            step_x_next = (e_start.x < e_end.x) ? step_x_reg + 6'd1 : step_x_reg - 6'd1;
        end
        if (c_y)
        begin
            step_y_next = (e_start.y < e_end.y) ? step_y_reg + 6'd1 : step_y_reg - 6'd1;
        end
        at_end = (step_x_reg == e_end.x) && (step_y_reg == e_end.y);
        off = step_y_reg - top_reg;
        in_range = ({1'b0, off} < 7'(ROWS));
    end

    // row RAM and merge stage
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata, cur_entry;
    coord_t             left_next, right_next;
    logic               last_row;
    logic               out_free;
    logic               span_load;

    always_comb
    begin
        cur_entry = (fwd_valid_reg && fwd_addr_reg == p1_addr_reg) ? fwd_data_reg : ram_rdata;
        left_next  = (p1_x_reg < cur_entry[ENTRY_W-1:COORD_W]) ? p1_x_reg
                                                              : cur_entry[ENTRY_W-1:COORD_W];
        right_next = (p1_x_reg > cur_entry[COORD_W-1:0]) ? p1_x_reg : cur_entry[COORD_W-1:0];

        ram_we    = p1_valid_reg;
        ram_waddr = p1_addr_reg;
        ram_wdata = {left_next, right_next};
        if (state_reg == S_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = row_idx_reg[AW-1:0];
            ram_wdata = {COL_MAX, COL_MIN};
        end

        ram_re    = 1'b0;
        ram_raddr = off[AW-1:0];
        if (state_reg == S_WALK)
        begin
            ram_re = in_range;
        end
        else if (state_reg == S_EMIT_RD)
        begin
            ram_re    = 1'b1;
            ram_raddr = row_idx_reg[AW-1:0];
        end

        last_row  = (row_idx_reg == count_reg - CW'(1));
        out_free  = !out_valid_reg || span.ready;
        span_load = (state_reg == S_EMIT_LD) && out_free;
    end

    tsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign triangle.ready = (state_reg == S_IDLE);
    assign span.valid     = out_valid_reg;
    assign span.data      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_reg       <= EDGE_01;
            row_idx_reg    <= '0;
            count_reg      <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            step_error_reg <= '0;
            p1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ram_we;
            fwd_addr_reg  <= ram_waddr;
            fwd_data_reg  <= ram_wdata;
            p1_valid_reg  <= (state_reg == S_WALK) && in_range;

            if (span_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (span.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (triangle.valid)
                    begin
                        v0_reg      <= s0;
                        v1_reg      <= s1;
                        v2_reg      <= s2;
                        top_reg     <= top_c;
                        count_reg   <= count_c;
                        char_reg    <= triangle.data.fill_char;
                        row_idx_reg <= '0;
                        state_reg   <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    if (last_row)
                    begin
                        edge_reg  <= EDGE_01;
                        state_reg <= S_SETUP;
                    end
                    else
                    begin
                        row_idx_reg <= row_idx_reg + CW'(1);
                    end
                end
                S_SETUP:
                begin
                    step_x_reg     <= e_start.x;
                    step_y_reg     <= e_start.y;
                    step_error_reg <= init_err[7:0];
                    state_reg      <= S_WALK;
                end
                S_WALK:
                begin
                    p1_x_reg     <= step_x_reg;
                    p1_addr_reg  <= off[AW-1:0];
                    if (at_end)
                    begin
                        unique case (edge_reg)
                            EDGE_01:
                            begin
                                edge_reg  <= EDGE_12;
                                state_reg <= S_SETUP;
                            end
                            EDGE_12:
                            begin
                                edge_reg  <= EDGE_02;
                                state_reg <= S_SETUP;
                            end
                            default:
                            begin
                                state_reg <= S_DRAIN;
                            end
                        endcase
                    end
                    else
                    begin
                        step_x_reg     <= step_x_next;
                        step_y_reg     <= step_y_next;
                        step_error_reg <= step_error_next;
                    end
                end
                S_DRAIN:
                begin
                    row_idx_reg <= '0;
                    state_reg   <= S_EMIT_RD;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        out_reg.row        <= top_reg + COORD_W'(row_idx_reg);
                        out_reg.span_start <= ram_rdata[ENTRY_W-1:COORD_W];
                        out_reg.span_end   <= ram_rdata[COORD_W-1:0];
                        out_reg.span_char  <= char_reg;
                        out_reg.last_span  <= last_row;
                        if (last_row)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_idx_reg <= row_idx_reg + CW'(1);
                            state_reg   <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_merge_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> $past(state_reg == S_WALK))
        else $error("merge stage loaded outside edge walk");

    a_span_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT_LD))
        else $error("span presented outside emit");

    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_LD) |-> !ram_we)
        else $error("row RAM written during emit");

    a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (edge_reg == EDGE_01 || edge_reg == EDGE_12 ||
                                   edge_reg == EDGE_02))
        else $error("bad edge code during walk");

endmodule

`default_nettype wire
